@@ src/euler_to_quaternion_defines.svh @@
// ----------------------------------------------------------------------------
// euler_to_quaternion_defines.svh
// Assertion macros for the Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define E2Q_ASSERT_HOLD(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// antecedent implies consequent in the next cycle
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define E2Q_ASSERT_HOLD(lbl, clk, rst_n, cond, msg)
`define E2Q_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/e2q_pkg.sv @@
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, CORDIC constants and the rounded Q2.30 product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int CORDIC_STEPS   = 30;
  localparam int XY_W           = 32;
  localparam int Z_W            = 34;
  localparam int Q_FRAC         = 30;
  localparam int COMBINE_STAGES = 3;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;

  localparam xy_t CORDIC_GAIN_INV = 32'sd652032874;
  localparam logic signed [2*XY_W-1:0] PROD_HALF = 64'sd536870912;

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Q2.30 times Q2.30, round half up, back to Q2.30
  function automatic xy_t qmul(xy_t a, xy_t b);
    logic signed [2*XY_W-1:0] prod;
    prod = a * b + PROD_HALF;
    return prod[Q_FRAC+XY_W-1:Q_FRAC];
  endfunction

endpackage

@@ src/e2q_cordic.sv @@
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation CORDIC: cosine and sine of half a binary angle, Q2.30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2q_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle_i,
  output e2q_pkg::xy_t                 cos_o,
  output e2q_pkg::xy_t                 sin_o
);

  localparam int STEPS = e2q_pkg::CORDIC_STEPS;
  localparam int ZSH   = 31 - ANGLE_BITS;

  e2q_pkg::xy_t x_r [STEPS+1];
  e2q_pkg::xy_t y_r [STEPS+1];
  e2q_pkg::z_t  z_r [STEPS+1];

  e2q_pkg::z_t  z0_nxt;

  assign z0_nxt = e2q_pkg::Z_W'(angle_i) <<< ZSH;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= e2q_pkg::CORDIC_GAIN_INV;
      y_r[0] <= '0;
      z_r[0] <= z0_nxt;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam e2q_pkg::z_t AT = e2q_pkg::Z_W'(e2q_pkg::ATAN_TABLE[i]);
    e2q_pkg::xy_t dx;
    e2q_pkg::xy_t dy;
    e2q_pkg::xy_t x_nxt;
    e2q_pkg::xy_t y_nxt;
    e2q_pkg::z_t  z_nxt;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_comb begin
      if (!z_r[i][e2q_pkg::Z_W-1]) begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - AT;
      end else begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + AT;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
      end
    end
  end

  assign cos_o = x_r[STEPS];
  assign sin_o = y_r[STEPS];

endmodule

@@ src/e2q_combine.sv @@
// ----------------------------------------------------------------------------
// e2q_combine
// Three-stage quaternion product: pair products, cross products, sum and
// saturate to Q1.(COMPONENT_BITS-1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2q_combine #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  e2q_pkg::xy_t                     cr_i,
  input  e2q_pkg::xy_t                     sr_i,
  input  e2q_pkg::xy_t                     cp_i,
  input  e2q_pkg::xy_t                     sp_i,
  input  e2q_pkg::xy_t                     cy_i,
  input  e2q_pkg::xy_t                     sy_i,
  output logic signed [COMPONENT_BITS-1:0] quat_w_o,
  output logic signed [COMPONENT_BITS-1:0] quat_x_o,
  output logic signed [COMPONENT_BITS-1:0] quat_y_o,
  output logic signed [COMPONENT_BITS-1:0] quat_z_o
);

  localparam int SUM_W = e2q_pkg::XY_W + 1;
  localparam int RND_W = SUM_W + 1;
  localparam int SH    = 31 - COMPONENT_BITS;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(64'sd1 <<< (SH - 1));
  localparam logic signed [RND_W-1:0] MAXV =
    RND_W'((64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] MINV = RND_W'(-(64'sd1 <<< (COMPONENT_BITS - 1)));

  function automatic logic signed [COMPONENT_BITS-1:0] to_comp(
    logic signed [SUM_W-1:0] v
  );
    logic signed [RND_W-1:0] rnd;
    logic signed [RND_W-1:0] r;
    rnd = RND_W'(v) + RND_HALF;
    r   = rnd >>> SH;
    if (r > MAXV) begin
      return MAXV[COMPONENT_BITS-1:0];
    end else if (r < MINV) begin
      return MINV[COMPONENT_BITS-1:0];
    end
    return r[COMPONENT_BITS-1:0];
  endfunction

  e2q_pkg::xy_t cpcy_r, spsy_r, cpsy_r, spcy_r, cr_r, sr_r;
  e2q_pkg::xy_t wa_r, wb_r, xa_r, xb_r, ya_r, yb_r, za_r, zb_r;

  logic signed [SUM_W-1:0] w_nxt, x_nxt, y_nxt, z_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      cpcy_r <= e2q_pkg::qmul(cp_i, cy_i);
      spsy_r <= e2q_pkg::qmul(sp_i, sy_i);
      cpsy_r <= e2q_pkg::qmul(cp_i, sy_i);
      spcy_r <= e2q_pkg::qmul(sp_i, cy_i);
      cr_r   <= cr_i;
      sr_r   <= sr_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r <= e2q_pkg::qmul(cr_r, cpcy_r);
      wb_r <= e2q_pkg::qmul(sr_r, spsy_r);
      xa_r <= e2q_pkg::qmul(sr_r, cpcy_r);
      xb_r <= e2q_pkg::qmul(cr_r, spsy_r);
      ya_r <= e2q_pkg::qmul(cr_r, spcy_r);
      yb_r <= e2q_pkg::qmul(sr_r, cpsy_r);
      za_r <= e2q_pkg::qmul(cr_r, cpsy_r);
      zb_r <= e2q_pkg::qmul(sr_r, spcy_r);
    end
  end

  assign w_nxt = SUM_W'(wa_r) + SUM_W'(wb_r);
  assign x_nxt = SUM_W'(xa_r) - SUM_W'(xb_r);
  assign y_nxt = SUM_W'(ya_r) + SUM_W'(yb_r);
  assign z_nxt = SUM_W'(za_r) - SUM_W'(zb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w_o <= to_comp(w_nxt);
      quat_x_o <= to_comp(x_nxt);
      quat_y_o <= to_comp(y_nxt);
      quat_z_o <= to_comp(z_nxt);
    end
  end

endmodule

@@ src/euler_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion: ZYX Euler angles to unit quaternion
// Pipeline: one load stage, 30 CORDIC stages, 3 product stages.
// Throughput one word per cycle; a stalled result word freezes the pipeline.
// Synchronous reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
  parameter int ANGLE_BITS     = 16,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ANGLE_BITS-1:0]     in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0]     in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]     in_yaw_angle,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COMPONENT_BITS-1:0] out_quat_w,
  output logic signed [COMPONENT_BITS-1:0] out_quat_x,
  output logic signed [COMPONENT_BITS-1:0] out_quat_y,
  output logic signed [COMPONENT_BITS-1:0] out_quat_z
);

  localparam int LAT = e2q_pkg::CORDIC_STEPS + 1 + e2q_pkg::COMBINE_STAGES;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  e2q_pkg::xy_t cr, sr, cp, sp, cy, sy;

  // advance unless a finished word is held at the output
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_roll (
    .clk(clk), .en(en), .angle_i(in_roll_angle), .cos_o(cr), .sin_o(sr)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
    .clk(clk), .en(en), .angle_i(in_pitch_angle), .cos_o(cp), .sin_o(sp)
  );

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_yaw (
    .clk(clk), .en(en), .angle_i(in_yaw_angle), .cos_o(cy), .sin_o(sy)
  );

  e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_combine (
    .clk      (clk),
    .en       (en),
    .cr_i     (cr),
    .sr_i     (sr),
    .cp_i     (cp),
    .sp_i     (sp),
    .cy_i     (cy),
    .sy_i     (sy),
    .quat_w_o (out_quat_w),
    .quat_x_o (out_quat_x),
    .quat_y_o (out_quat_y),
    .quat_z_o (out_quat_z)
  );

  `E2Q_ASSERT_NEXT(a_capture, clk, rst_n, in_valid && !in_stall, vld_r[0], "accepted word not captured")
  `E2Q_ASSERT_NEXT(a_tail, clk, rst_n, vld_r[LAT-2] && !in_stall, out_valid, "word lost before output")
  `E2Q_ASSERT_NEXT(a_freeze, clk, rst_n, out_valid && out_stall, $stable(vld_r), "pipeline moved under stall")

endmodule

@@ verif/euler_to_quaternion_tb.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// Drives roll, pitch and yaw words into the converter in random bursts while
// the result side stalls in changing patterns. A fixed-point model of the
// half-angle CORDIC and the quaternion products predicts every result word,
// and each accepted result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_to_quaternion_tb;

  localparam int ANGLE_W    = 16;
  localparam int COMP_W     = 16;
  localparam int RAND_WORDS = 950;
  localparam int DRAIN_CYC  = 60;

  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam longint ATAN_Q32 [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
  } attitude_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] w;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } quat_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_roll_angle  = '0;
  logic signed [ANGLE_W-1:0] in_pitch_angle = '0;
  logic signed [ANGLE_W-1:0] in_yaw_angle   = '0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic signed [COMP_W-1:0]  out_quat_w;
  logic signed [COMP_W-1:0]  out_quat_x;
  logic signed [COMP_W-1:0]  out_quat_y;
  logic signed [COMP_W-1:0]  out_quat_z;

  attitude_t   attitude_q [$];
  quat_t       quat_q [$];
  logic        in_taken   = 1'b0;
  int          burst_left = 0;
  int          gap_left   = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_tick = 0;
  int          err_count  = 0;

  euler_to_quaternion #(
    .ANGLE_BITS    (ANGLE_W),
    .COMPONENT_BITS(COMP_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_roll_angle (in_roll_angle),
    .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle  (in_yaw_angle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quat_w    (out_quat_w),
    .out_quat_x    (out_quat_x),
    .out_quat_y    (out_quat_y),
    .out_quat_z    (out_quat_z)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // cosine and sine of half the binary angle, Q2.30
  function automatic void half_angle_sincos(input logic signed [ANGLE_W-1:0] ang,
                                            output longint c, output longint s);
    longint xv, yv, zv, dx, dy;
    xv = GAIN_Q30;
    yv = 0;
    zv = longint'(ang) * (64'sd1 <<< (31 - ANGLE_W));
    for (int i = 0; i < 30; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (zv >= 0) begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - ATAN_Q32[i];
      end else begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + ATAN_Q32[i];
      end
    end
    c = xv;
    s = yv;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [COMP_W-1:0] q30_to_component(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (30 - COMP_W))) >>> (31 - COMP_W);
    if (r > (64'sd1 <<< (COMP_W - 1)) - 1) r = (64'sd1 <<< (COMP_W - 1)) - 1;
    if (r < -(64'sd1 <<< (COMP_W - 1))) r = -(64'sd1 <<< (COMP_W - 1));
    return r[COMP_W-1:0];
  endfunction

  function automatic quat_t quat_from_euler(input attitude_t a);
    longint cr, sr, cp, sp, cy, sy;
    longint cpcy, spsy, cpsy, spcy;
    quat_t  q;
    half_angle_sincos(a.roll, cr, sr);
    half_angle_sincos(a.pitch, cp, sp);
    half_angle_sincos(a.yaw, cy, sy);
    cpcy = q30_product(cp, cy);
    spsy = q30_product(sp, sy);
    cpsy = q30_product(cp, sy);
    spcy = q30_product(sp, cy);
    q.w = q30_to_component(q30_product(cr, cpcy) + q30_product(sr, spsy));
    q.x = q30_to_component(q30_product(sr, cpcy) - q30_product(cr, spsy));
    q.y = q30_to_component(q30_product(cr, spcy) + q30_product(sr, cpsy));
    q.z = q30_to_component(q30_product(cr, cpsy) - q30_product(sr, spcy));
    return q;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] pick_angle(input int kind);
    int k;
    k = $urandom_range(0, 31);
    case (kind)
      6: return ANGLE_W'($urandom_range(0, 128) - 64);
      7: return ($urandom_range(0, 1) != 0) ? ANGLE_W'(-32768 + k) : ANGLE_W'(32767 - k);
      8: return ANGLE_W'($urandom_range(0, 7) * 8192 + $urandom_range(0, 8) - 4);
      default: return ANGLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_attitude(input int r, input int p, input int y);
    attitude_t a;
    a.roll  = ANGLE_W'(r);
    a.pitch = ANGLE_W'(p);
    a.yaw   = ANGLE_W'(y);
    attitude_q.push_back(a);
  endtask

  // driver: advance on acceptance, hold while stalled
  always @(negedge clk) begin
    attitude_t a;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (attitude_q.size() != 0) begin
        a = attitude_q.pop_front();
        in_roll_angle  <= a.roll;
        in_pitch_angle <= a.pitch;
        in_yaw_angle   <= a.yaw;
        in_valid       <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall pattern
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(20, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_tick % 5) < 2;
    endcase
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    quat_t e;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        quat_q.push_back(quat_from_euler({in_roll_angle, in_pitch_angle, in_yaw_angle}));
      end
      if (out_valid && !out_stall) begin
        if (quat_q.size() == 0) begin
          flag_error("result word with nothing expected");
        end else begin
          e = quat_q.pop_front();
          if (out_quat_w !== e.w)
            flag_error($sformatf("w got %0d expected %0d", out_quat_w, e.w));
          if (out_quat_x !== e.x)
            flag_error($sformatf("x got %0d expected %0d", out_quat_x, e.x));
          if (out_quat_y !== e.y)
            flag_error($sformatf("y got %0d expected %0d", out_quat_y, e.y));
          if (out_quat_z !== e.z)
            flag_error($sformatf("z got %0d expected %0d", out_quat_z, e.z));
        end
      end
    end
  end

  initial begin
    int kind;
    attitude_t a;
    // zero attitude: w is +1.0 and saturates
    queue_attitude(0, 0, 0);
    // -pi on each axis: half-angle lands exactly on -pi/2
    queue_attitude(-32768, 0, 0);
    queue_attitude(0, -32768, 0);
    queue_attitude(0, 0, -32768);
    queue_attitude(-32768, -32768, -32768);
    queue_attitude(32767, 32767, 32767);
    queue_attitude(32767, 0, 0);
    queue_attitude(0, 32767, 0);
    queue_attitude(0, 0, 32767);
    queue_attitude(16384, 0, 0);
    queue_attitude(0, 16384, 0);
    queue_attitude(0, 0, 16384);
    queue_attitude(-16384, -16384, -16384);
    queue_attitude(1, -1, 1);
    queue_attitude(-1, 1, -1);
    queue_attitude(-32768, 32767, 0);
    queue_attitude(32767, -32768, 16384);
    queue_attitude(21845, -21846, 21845);
    queue_attitude(-21846, 21845, -21846);
    queue_attitude(8192, -8192, 24576);
    for (int n = 0; n < RAND_WORDS; n++) begin
      kind = $urandom_range(0, 9);
      a.roll  = pick_angle(kind);
      a.pitch = pick_angle(kind);
      a.yaw   = pick_angle(kind);
      if (kind == 9) begin
        case ($urandom_range(0, 2))
          0:       begin a.pitch = '0; a.yaw = '0; end
          1:       begin a.roll = '0; a.yaw = '0; end
          default: begin a.roll = '0; a.pitch = '0; end
        endcase
      end
      attitude_q.push_back(a);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (attitude_q.size() != 0 || in_valid) @(posedge clk);
    while (quat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0) begin
      $display("euler_to_quaternion_tb: done, clean");
    end else begin
      $display("euler_to_quaternion_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("euler_to_quaternion_tb: done, errors");
    $finish;
  end

endmodule
